// ===== rtl/pts_pkg.sv =====
package pts_pkg;

  // Commands carried by the input item.
  typedef enum logic [2:0] {
    CMD_CLEAR_ALL = 3'd0,
    CMD_HTAB      = 3'd1,
    CMD_VTAB      = 3'd2,
    CMD_HSET      = 3'd3,
    CMD_VSET      = 3'd4,
    CMD_SET_BYTE  = 3'd5,
    CMD_HINC      = 3'd6,
    CMD_NOP       = 3'd7
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_CHAR_SPACING = 1'b0,
    REG_LINE_SPACING = 1'b1
  } reg_idx_t;

  localparam logic [7:0]  RESET_CHAR_SPACING = 8'd36;
  localparam logic [7:0]  RESET_LINE_SPACING = 8'd60;
  localparam logic [15:0] TAB_STEP           = 16'd8;
  // Horizontal stop spacing after reset: eight columns of the reset character width.
  localparam logic [15:0] RESET_FILL_INC     = 16'd288;

  typedef enum logic [2:0] {
    ST_BOOT,
    ST_BOOT_FILL,
    ST_IDLE,
    ST_EXEC,
    ST_FILL,
    ST_SEARCH,
    ST_CLEAR,
    ST_RESULT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_TAKE,
    OP_FILL_INIT,
    OP_FILL_STEP,
    OP_SEARCH_INIT,
    OP_SEARCH_STEP,
    OP_SET_START,
    OP_SET_BYTE,
    OP_CLEAR_STEP
  } dp_op_t;

  typedef enum logic [1:0] {
    FILL_RESET,
    FILL_ALL,
    FILL_HINC
  } fill_mode_t;

  typedef struct packed {
    dp_op_t     op;
    fill_mode_t mode;
    logic       load_out;
  } dp_ctrl_t;

  typedef struct packed {
    cmd_t cmd;
    logic chan_ok;
    logic in_progress;
    logic byte_ends;
    logic fill_last;
    logic srch_hit;
    logic srch_end;
    logic set_last;
  } dp_status_t;

endpackage

// ===== rtl/pts_ram.sv =====
module pts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pts_ctrl.sv =====
module pts_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output pts_pkg::dp_ctrl_t   ctrl,
  input  pts_pkg::dp_status_t status
);
  import pts_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_BOOT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_BOOT: begin
        state_next = ST_BOOT_FILL;
      end
      ST_BOOT_FILL: begin
        if (status.fill_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        case (status.cmd)
          CMD_CLEAR_ALL, CMD_HINC: state_next = ST_FILL;
          CMD_HTAB: state_next = ST_SEARCH;
          CMD_VTAB: state_next = status.chan_ok ? ST_SEARCH : ST_RESULT;
          CMD_SET_BYTE: begin
            if (status.in_progress && status.byte_ends) state_next = ST_CLEAR;
            else state_next = ST_RESULT;
          end
          default: state_next = ST_RESULT;
        endcase
      end
      ST_FILL: begin
        if (status.fill_last) state_next = ST_RESULT;
      end
      ST_SEARCH: begin
        if (status.srch_hit || status.srch_end) state_next = ST_RESULT;
      end
      ST_CLEAR: begin
        if (status.set_last) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_BOOT;
    endcase
  end

  always_comb begin
    ctrl = '{op: OP_NONE, mode: FILL_ALL, load_out: 1'b0};
    case (state)
      ST_BOOT: begin
        ctrl.op   = OP_FILL_INIT;
        ctrl.mode = FILL_RESET;
      end
      ST_BOOT_FILL, ST_FILL: begin
        ctrl.op = OP_FILL_STEP;
      end
      ST_IDLE: begin
        if (in_valid) ctrl.op = OP_TAKE;
      end
      ST_EXEC: begin
        case (status.cmd)
          CMD_CLEAR_ALL: begin
            ctrl.op   = OP_FILL_INIT;
            ctrl.mode = FILL_ALL;
          end
          CMD_HINC: begin
            ctrl.op   = OP_FILL_INIT;
            ctrl.mode = FILL_HINC;
          end
          CMD_HTAB, CMD_VTAB: ctrl.op = OP_SEARCH_INIT;
          CMD_HSET, CMD_VSET: ctrl.op = OP_SET_START;
          CMD_SET_BYTE: begin
            if (status.in_progress && !status.byte_ends) ctrl.op = OP_SET_BYTE;
          end
          default: ctrl.op = OP_NONE;
        endcase
      end
      ST_SEARCH: begin
        ctrl.op = OP_SEARCH_STEP;
      end
      ST_CLEAR: begin
        ctrl.op = OP_CLEAR_STEP;
      end
      ST_RESULT: begin
        ctrl.load_out = out_free;
      end
      default: ctrl.op = OP_NONE;
    endcase
  end

  a_boot_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BOOT || state == ST_BOOT_FILL) |-> (in_stall && !out_valid))
    else $error("item or result during the boot sweep");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_EXEC))
    else $error("accepted transfer not decoded");

  a_result_once: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESULT && out_free) |=> (out_valid && state == ST_IDLE))
    else $error("result not presented");

endmodule

// ===== rtl/pts_dp.sv =====
module pts_dp #(
  parameter int H_STOPS    = 32,
  parameter int V_STOPS    = 16,
  parameter int V_CHANNELS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic [2:0]          command,
  input  logic [15:0]         position,
  input  logic [2:0]          channel,
  input  logic [7:0]          value,
  input  pts_pkg::dp_ctrl_t   ctrl,
  output pts_pkg::dp_status_t status,
  output logic [15:0]         new_position,
  output logic                setting_active
);
  import pts_pkg::*;

  localparam int VN      = V_CHANNELS * V_STOPS;
  localparam int SWEEP_N = (VN > H_STOPS) ? VN : H_STOPS;
  localparam int MAXLEN  = (V_STOPS > H_STOPS) ? V_STOPS : H_STOPS;
  localparam int CW      = $clog2(SWEEP_N);
  localparam int HAW     = $clog2(H_STOPS);
  localparam int VAW     = $clog2(VN);
  localparam int SIW     = $clog2(MAXLEN);

  // Latched item.
  cmd_t        cmd_q;
  logic [15:0] pos_q;
  logic [2:0]  chan_q;
  logic [7:0]  val_q;

  logic [7:0]  char_spacing;
  logic [7:0]  line_spacing;

  // Sweep and search state.
  logic [CW-1:0] cnt;
  logic [16:0]   acc;
  logic [15:0]   inc;
  fill_mode_t    fill_mode_q;
  logic          cmp_valid;
  logic          cmp_last;
  logic [15:0]   result;

  // Open set sequence.
  logic           set_prog;
  logic           set_vert;
  logic [2:0]     set_chan;
  logic [SIW-1:0] set_idx;
  logic [7:0]     prev_byte;

  logic           chan_ok;
  logic           srch_vert;
  logic [CW-1:0]  srch_last;
  logic [CW-1:0]  fill_last_idx;
  logic           set_last;
  logic [15:0]    byte_prod;
  logic [17:0]    sum;
  logic [16:0]    acc_next;
  logic [15:0]    acc_sat;
  logic [VAW-1:0] vbase_set;
  logic [VAW-1:0] vbase_srch;
  logic [15:0]    h_rdata;
  logic [15:0]    v_rdata;
  logic [15:0]    rdata;
  logic           hit;
  logic           fill_op;
  logic           set_op;

  logic           h_we;
  logic [HAW-1:0] h_waddr;
  logic [15:0]    h_wdata;
  logic [HAW-1:0] h_raddr;
  logic           v_we;
  logic [VAW-1:0] v_waddr;
  logic [15:0]    v_wdata;
  logic [VAW-1:0] v_raddr;

  assign chan_ok   = ({2'b00, chan_q} < 5'(V_CHANNELS));
  assign srch_vert = (cmd_q == CMD_VTAB);
  assign srch_last = srch_vert ? CW'(V_STOPS - 1) : CW'(H_STOPS - 1);
  assign fill_last_idx = (fill_mode_q == FILL_HINC) ? CW'(H_STOPS - 1) : CW'(SWEEP_N - 1);
  assign set_last  = set_vert ? (set_idx == SIW'(V_STOPS - 1))
                              : (set_idx == SIW'(H_STOPS - 1));
  assign byte_prod = 16'(val_q) * 16'(set_vert ? line_spacing : char_spacing);

  // Running product x*step, clamped just above the 16-bit range.
  assign sum      = 18'(acc) + 18'(inc);
  assign acc_next = (sum > 18'h10000) ? 17'h10000 : sum[16:0];
  assign acc_sat  = acc[16] ? 16'hFFFF : acc[15:0];

  assign vbase_set  = VAW'(set_chan) * VAW'(V_STOPS);
  assign vbase_srch = VAW'(chan_q) * VAW'(V_STOPS);

  assign rdata = srch_vert ? v_rdata : h_rdata;
  assign hit   = cmp_valid && (rdata > pos_q);

  assign fill_op = (ctrl.op == OP_FILL_STEP);
  assign set_op  = (ctrl.op == OP_SET_BYTE) || (ctrl.op == OP_CLEAR_STEP);

  assign h_we    = (fill_op && ({1'b0, cnt} < (CW+1)'(H_STOPS))) || (set_op && !set_vert);
  assign h_waddr = fill_op ? HAW'(cnt) : HAW'(set_idx);
  assign h_wdata = fill_op ? acc_sat : ((ctrl.op == OP_SET_BYTE) ? byte_prod : 16'd0);
  assign h_raddr = HAW'(cnt);

  assign v_we    = (fill_op && fill_mode_q != FILL_HINC && ({1'b0, cnt} < (CW+1)'(VN)))
                   || (set_op && set_vert);
  assign v_waddr = fill_op ? VAW'(cnt) : (vbase_set + VAW'(set_idx));
  assign v_wdata = (ctrl.op == OP_SET_BYTE) ? byte_prod : 16'd0;
  assign v_raddr = vbase_srch + VAW'(cnt);

  pts_ram #(.WIDTH(16), .DEPTH(H_STOPS)) u_hram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  pts_ram #(.WIDTH(16), .DEPTH(VN)) u_vram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  always_comb begin
    status.cmd         = cmd_q;
    status.chan_ok     = chan_ok;
    status.in_progress = set_prog;
    status.byte_ends   = (val_q == 8'd0) || (val_q < prev_byte);
    status.fill_last   = (cnt == fill_last_idx);
    status.srch_hit    = hit;
    status.srch_end    = cmp_valid && cmp_last;
    status.set_last    = set_last;
  end

  // Control and configuration state.
  always_ff @(posedge clk) begin
    if (rst) begin
      char_spacing <= RESET_CHAR_SPACING;
      line_spacing <= RESET_LINE_SPACING;
      cmp_valid    <= 1'b0;
      set_prog     <= 1'b0;
      set_vert     <= 1'b0;
      set_chan     <= 3'd0;
      set_idx      <= '0;
      prev_byte    <= 8'd0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_CHAR_SPACING: char_spacing <= cfg_data;
          REG_LINE_SPACING: line_spacing <= cfg_data;
          default: ;
        endcase
      end
      case (ctrl.op)
        OP_SEARCH_INIT: cmp_valid <= 1'b0;
        OP_SEARCH_STEP: cmp_valid <= 1'b1;
        OP_SET_START: begin
          if (cmd_q == CMD_HSET) begin
            set_prog  <= 1'b1;
            set_vert  <= 1'b0;
            set_chan  <= 3'd0;
            set_idx   <= '0;
            prev_byte <= 8'd0;
          end else if (chan_ok) begin
            set_prog  <= 1'b1;
            set_vert  <= 1'b1;
            set_chan  <= chan_q;
            set_idx   <= '0;
            prev_byte <= 8'd0;
          end else begin
            set_prog <= 1'b0;
          end
        end
        OP_SET_BYTE: begin
          prev_byte <= val_q;
          set_idx   <= set_idx + 1'b1;
          if (set_last) set_prog <= 1'b0;
        end
        OP_CLEAR_STEP: begin
          set_idx <= set_idx + 1'b1;
          if (set_last) set_prog <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_TAKE: begin
        cmd_q  <= cmd_t'(command);
        pos_q  <= position;
        chan_q <= channel;
        val_q  <= value;
        result <= position;
      end
      OP_FILL_INIT: begin
        cnt         <= '0;
        acc         <= 17'd0;
        fill_mode_q <= ctrl.mode;
        case (ctrl.mode)
          FILL_RESET: inc <= RESET_FILL_INC;
          FILL_ALL:   inc <= 16'(char_spacing) * TAB_STEP;
          FILL_HINC:  inc <= 16'(val_q) * 16'(char_spacing);
          default:    inc <= 16'd0;
        endcase
      end
      OP_FILL_STEP: begin
        cnt <= cnt + 1'b1;
        acc <= acc_next;
      end
      OP_SEARCH_INIT: begin
        cnt <= '0;
      end
      OP_SEARCH_STEP: begin
        cnt      <= (cnt == srch_last) ? cnt : cnt + 1'b1;
        cmp_last <= (cnt == srch_last);
        if (hit) result <= rdata;
      end
      default: ;
    endcase
    if (ctrl.load_out) begin
      new_position   <= result;
      setting_active <= set_prog;
    end
  end

  a_set_idx_range: assert property (@(posedge clk) disable iff (rst)
    set_prog |-> (set_vert ? ({1'b0, set_idx} < (SIW+1)'(V_STOPS))
                           : ({1'b0, set_idx} < (SIW+1)'(H_STOPS))))
    else $error("set index past the end of its table");

  a_set_chan_range: assert property (@(posedge clk) disable iff (rst)
    (set_prog && set_vert) |-> ({2'b00, set_chan} < 5'(V_CHANNELS)))
    else $error("vertical set on a channel that does not exist");

endmodule

// ===== rtl/printer_tab_stop_unit_top.sv =====
// Channel  Handshake           Payload
// in       in_valid/in_stall   command, position, channel, value
// out      out_valid/out_stall new_position, setting_active
// cfg      cfg_we              cfg_index, cfg_data (0 char_spacing, 1 line_spacing)
//
// One item is in work at a time; the next is accepted once the finished result sits in
// the output register, so a stalled output only holds back the item after that.
// A tab search walks the stop table through the RAM read port. h_increment and
// clear_all sweep the tables at one RAM write per cycle; a set ending early clears
// the rest at one stop per cycle. After reset a fill pass loads the stop tables
// while the input is stalled; config writes are taken.
module printer_tab_stop_unit_top #(
  parameter int H_STOPS    = 32,
  parameter int V_STOPS    = 16,
  parameter int V_CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [15:0] position,
  input  logic [2:0]  channel,
  input  logic [7:0]  value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] new_position,
  output logic        setting_active
);
  import pts_pkg::*;

  // The controller sequences each command; the datapath holds the tables, the
  // configuration and the set sequence state.
  dp_ctrl_t   ctrl;
  dp_status_t status;

  pts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl),
    .status    (status)
  );

  pts_dp #(
    .H_STOPS    (H_STOPS),
    .V_STOPS    (V_STOPS),
    .V_CHANNELS (V_CHANNELS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .command        (command),
    .position       (position),
    .channel        (channel),
    .value          (value),
    .ctrl           (ctrl),
    .status         (status),
    .new_position   (new_position),
    .setting_active (setting_active)
  );

endmodule

// ===== tb/sv/tb_printer_tab_stop_unit_top.sv =====
`timescale 1ns / 1ps

module tb_printer_tab_stop_unit_top;
  import pts_pkg::*;

  localparam int H_STOPS         = 32;
  localparam int V_STOPS         = 16;
  localparam int V_CHANNELS      = 8;
  localparam int ITEMS_PER_PHASE = 225;
  localparam int RANDOM_PHASES   = 6;
  // Cycles without any transfer before the run is declared hung. The slowest
  // single command is clear_all, and the long output hold-off adds to that,
  // so this leaves a wide margin.
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int HOLD_CYCLES     = 400;
  // The hold-off starts well inside the first random phase, while plenty of
  // commands are still queued for the driver.
  localparam int HOLD_AT_RESULT  = 120;

  // One command as the block receives it.
  typedef struct packed {
    cmd_t        op;
    logic [15:0] pos;
    logic [2:0]  chan;
    logic [7:0]  val;
  } tab_cmd_t;

  // One result as the block returns it.
  typedef struct packed {
    logic [15:0] new_position;
    logic        setting_active;
  } tab_result_t;

  // Every input of the block starts at a known value.
  logic        clk            = 1'b0;
  logic        rst            = 1'b1;
  logic        cfg_we         = 1'b0;
  logic [0:0]  cfg_index      = REG_CHAR_SPACING;
  logic [7:0]  cfg_data       = 8'd0;
  logic        in_valid       = 1'b0;
  logic [2:0]  command        = CMD_NOP;
  logic [15:0] position       = 16'd0;
  logic [2:0]  channel        = 3'd0;
  logic [7:0]  value          = 8'd0;
  logic        out_stall      = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [15:0] new_position;
  logic        setting_active;

  // Commands waiting to be offered, and results predicted for accepted ones.
  tab_cmd_t    pending_cmds[$];
  tab_result_t predicted_tab_results[$];

  // Idle rates in percent, changed by the stimulus between phases.
  int          send_idle_pct  = 0;
  int          recv_idle_pct  = 0;
  int          errors         = 0;
  int          results_seen   = 0;

  // Predictor state: its own copy of the stop tables, the open set sequence
  // and the two spacing registers.
  logic [15:0] h_stop_tab[H_STOPS];
  logic [15:0] v_stop_tab[V_CHANNELS * V_STOPS];
  bit          set_open;
  bit          set_vert;
  int unsigned set_chan;
  int unsigned set_idx;
  logic [7:0]  prev_byte;
  logic [7:0]  char_sp_model;
  logic [7:0]  line_sp_model;

  printer_tab_stop_unit_top #(
    .H_STOPS   (H_STOPS),
    .V_STOPS   (V_STOPS),
    .V_CHANNELS(V_CHANNELS)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .position      (position),
    .channel       (channel),
    .value         (value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .new_position  (new_position),
    .setting_active(setting_active)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Stops are 16-bit positions; anything larger is held at the top value.
  function automatic logic [15:0] clamp16(int unsigned v);
    return (v > 32'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  // Horizontal stop x goes to x * incr * character width.
  function automatic void load_h_stops(int unsigned incr);
    for (int unsigned x = 0; x < H_STOPS; x++) begin
      h_stop_tab[x] = clamp16(x * incr * char_sp_model);
    end
  endfunction

  // First stop in table order strictly beyond pos; pos itself when none is.
  function automatic logic [15:0] first_stop_above(bit vert, int unsigned base,
                                                   int unsigned len, logic [15:0] pos);
    logic [15:0] s;
    for (int unsigned x = 0; x < len; x++) begin
      s = vert ? v_stop_tab[base + x] : h_stop_tab[x];
      if (s > pos) return s;
    end
    return pos;
  endfunction

  // Writes one entry of the table that the open set sequence targets.
  function automatic void store_stop(int unsigned idx, logic [15:0] v);
    if (set_vert) begin
      v_stop_tab[set_chan * V_STOPS + idx] = v;
    end else begin
      h_stop_tab[idx] = v;
    end
  endfunction

  // Advances the predictor by one accepted command and returns its result.
  function automatic tab_result_t apply_tab_command(tab_cmd_t c);
    tab_result_t r;
    int unsigned tab_len;
    int unsigned spacing;
    r.new_position = c.pos;
    case (c.op)
      CMD_CLEAR_ALL: begin
        for (int i = 0; i < V_CHANNELS * V_STOPS; i++) v_stop_tab[i] = 16'd0;
        load_h_stops(32'(TAB_STEP));
      end
      CMD_HTAB: r.new_position = first_stop_above(1'b0, 0, H_STOPS, c.pos);
      CMD_VTAB: begin
        if (c.chan < V_CHANNELS) begin
          r.new_position = first_stop_above(1'b1, c.chan * V_STOPS, V_STOPS, c.pos);
        end
      end
      CMD_HSET: begin
        set_open  = 1'b1;
        set_vert  = 1'b0;
        set_chan  = 0;
        set_idx   = 0;
        prev_byte = 8'd0;
      end
      CMD_VSET: begin
        if (c.chan < V_CHANNELS) begin
          set_open  = 1'b1;
          set_vert  = 1'b1;
          set_chan  = c.chan;
          set_idx   = 0;
          prev_byte = 8'd0;
        end else begin
          set_open = 1'b0;
        end
      end
      CMD_SET_BYTE: begin
        // A byte with no open sequence falls through untouched.
        if (set_open) begin
          tab_len = set_vert ? V_STOPS : H_STOPS;
          spacing = set_vert ? line_sp_model : char_sp_model;
          if (c.val == 8'd0 || c.val < prev_byte) begin
            // The sequence ends early: the stops not yet written are cleared.
            while (set_idx < tab_len) begin
              store_stop(set_idx, 16'd0);
              set_idx++;
            end
            set_open = 1'b0;
          end else begin
            if (set_idx < tab_len) store_stop(set_idx, clamp16(32'(c.val) * spacing));
            set_idx++;
            prev_byte = c.val;
            if (set_idx >= tab_len) set_open = 1'b0;
          end
        end
      end
      CMD_HINC: load_h_stops(32'(c.val));
      default: ;
    endcase
    r.setting_active = set_open;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued commands on the input channel. A stalled transfer
  // keeps its payload; a new command is only loaded once the previous one
  // was taken or nothing was offered. The predictor runs on what the block
  // actually accepted, read back from the ports at the accepting edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_cmds
    tab_cmd_t taken;
    tab_cmd_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        taken.op   = cmd_t'(command);
        taken.pos  = position;
        taken.chan = channel;
        taken.val  = value;
        predicted_tab_results.push_back(apply_tab_command(taken));
      end
      if (!in_valid || !in_stall) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_cmds.pop_front();
          command  <= nxt.op;
          position <= nxt.pos;
          channel  <= nxt.chan;
          value    <= nxt.val;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: drives the output stall and checks every transfer on the output
  // channel against the oldest prediction. Once, after a fixed number of
  // results, it holds the output off for a long stretch so that the block
  // backs up and stalls its input while the driver keeps offering commands.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    tab_result_t want;
    int hold_left;
    bit hold_done;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (predicted_tab_results.size() == 0) begin
          errors++;
          $display("%0t: result with none outstanding: expected nothing, actual %h/%b",
                   $time, new_position, setting_active);
        end else begin
          want = predicted_tab_results.pop_front();
          if (new_position !== want.new_position) begin
            errors++;
            $display("%0t: new_position mismatch: expected %h, actual %h",
                     $time, want.new_position, new_position);
          end
          if (setting_active !== want.setting_active) begin
            errors++;
            $display("%0t: setting_active mismatch: expected %b, actual %b",
                     $time, want.setting_active, setting_active);
          end
        end
        if (results_seen == HOLD_AT_RESULT && !hold_done) begin
          hold_left = HOLD_CYCLES;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // The watchdog restarts on any transfer on either channel.
  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet == WATCHDOG_LIMIT) begin
        $display("%0t: watchdog: no transfer for %0d cycles", $time, quiet);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic void queue_cmd(cmd_t op, logic [15:0] pos, logic [2:0] chan,
                                    logic [7:0] val);
    tab_cmd_t c;
    c.op   = op;
    c.pos  = pos;
    c.chan = chan;
    c.val  = val;
    pending_cmds.push_back(c);
  endfunction

  // Head positions: full range, the band where stops usually sit, and low.
  function automatic logic [15:0] pick_position();
    case ($urandom_range(2))
      0:       return 16'($urandom_range(65535));
      1:       return 16'($urandom_range(12000));
      default: return 16'($urandom_range(600));
    endcase
  endfunction

  // Waits until every queued command has been taken and its result checked.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_valid || predicted_tab_results.size() != 0);
  endtask

  // Register writes happen only while the block holds no work.
  task automatic write_cfg(reg_idx_t idx, logic [7:0] d);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    if (idx == REG_CHAR_SPACING) begin
      char_sp_model = d;
    end else begin
      line_sp_model = d;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int counted;
    int pick;
    int tab_len;
    int nbytes;
    int ending;
    int stepmax;
    int b;
    int last_b;
    bit vert;
    logic [2:0] ch;
    logic [7:0] cs_next;
    logic [7:0] ls_next;

    // Predictor reset state mirrors the block after its boot fill.
    char_sp_model = RESET_CHAR_SPACING;
    line_sp_model = RESET_LINE_SPACING;
    for (int i = 0; i < V_CHANNELS * V_STOPS; i++) v_stop_tab[i] = 16'd0;
    load_h_stops(32'(TAB_STEP));
    set_open  = 1'b0;
    set_vert  = 1'b0;
    set_chan  = 0;
    set_idx   = 0;
    prev_byte = 8'd0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part, at the reset spacings (36 per column, 60 per line).
    @(negedge clk);
    send_idle_pct = 17;
    recv_idle_pct = 75;
    queue_cmd(CMD_HTAB, 16'd0, 3'd0, 8'd0);          // first stop beyond zero
    queue_cmd(CMD_HTAB, 16'hFFFF, 3'd7, 8'hFF);      // top position, nothing beyond
    queue_cmd(CMD_HTAB, 16'd8928, 3'd0, 8'd0);       // exactly on the last stop
    queue_cmd(CMD_VTAB, 16'd0, 3'd0, 8'd0);          // vertical stops all zero
    queue_cmd(CMD_NOP, 16'h5A5A, 3'd5, 8'hA5);       // command seven passes through
    queue_cmd(CMD_SET_BYTE, 16'd1, 3'd0, 8'hFF);     // stray byte, no sequence open
    // Vertical set on the last channel, ended by a zero byte.
    queue_cmd(CMD_VSET, 16'd0, 3'd7, 8'd0);
    queue_cmd(CMD_SET_BYTE, 16'd0, 3'd0, 8'd1);
    queue_cmd(CMD_SET_BYTE, 16'd0, 3'd0, 8'd2);
    queue_cmd(CMD_SET_BYTE, 16'd0, 3'd0, 8'd255);
    queue_cmd(CMD_SET_BYTE, 16'd0, 3'd0, 8'd0);
    queue_cmd(CMD_VTAB, 16'd100, 3'd7, 8'd0);
    // Horizontal set ended by a byte lower than the one before.
    queue_cmd(CMD_HSET, 16'd0, 3'd0, 8'd0);
    queue_cmd(CMD_SET_BYTE, 16'd0, 3'd0, 8'd3);
    queue_cmd(CMD_SET_BYTE, 16'd0, 3'd0, 8'd5);
    queue_cmd(CMD_SET_BYTE, 16'd0, 3'd0, 8'd2);
    queue_cmd(CMD_HTAB, 16'd0, 3'd0, 8'd0);
    // Restart: a vertical start abandons the open horizontal sequence, which
    // keeps its old remaining stops; a tab in the middle runs normally.
    queue_cmd(CMD_HSET, 16'd0, 3'd0, 8'd0);
    queue_cmd(CMD_SET_BYTE, 16'd0, 3'd0, 8'd4);
    queue_cmd(CMD_VSET, 16'd0, 3'd2, 8'd0);
    queue_cmd(CMD_SET_BYTE, 16'd0, 3'd0, 8'd1);
    queue_cmd(CMD_HTAB, 16'd144, 3'd0, 8'd0);
    // Saturation of the increment fill, then clear_all restores the defaults.
    queue_cmd(CMD_HINC, 16'd0, 3'd0, 8'd255);
    queue_cmd(CMD_HTAB, 16'd60000, 3'd0, 8'd0);
    queue_cmd(CMD_CLEAR_ALL, 16'd0, 3'd0, 8'd0);

    // Random phases, each at its own spacing. Idling: sender rarely and
    // receiver often, then the reverse, then no idling at all.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      case (p)
        0:       begin cs_next = 8'd255; ls_next = 8'd255; end
        1:       begin cs_next = 8'd0;   ls_next = 8'd0;   end
        2:       begin cs_next = 8'd1;   ls_next = 8'd255; end
        3:       begin cs_next = 8'($urandom_range(255)); ls_next = 8'($urandom_range(255)); end
        4:       begin cs_next = 8'($urandom_range(255)); ls_next = 8'd1; end
        default: begin cs_next = RESET_CHAR_SPACING; ls_next = RESET_LINE_SPACING; end
      endcase
      write_cfg(REG_CHAR_SPACING, cs_next);
      write_cfg(REG_LINE_SPACING, ls_next);
      @(negedge clk);
      send_idle_pct = (p < 2) ? 17 : (p < 4) ? 75 : 0;
      recv_idle_pct = (p < 2) ? 75 : (p < 4) ? 17 : 0;

      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          // A well-formed set sequence with random content, then probing tabs.
          vert    = $urandom_range(1);
          ch      = 3'($urandom_range(7));
          tab_len = vert ? V_STOPS : H_STOPS;
          queue_cmd(vert ? CMD_VSET : CMD_HSET, pick_position(), ch, 8'($urandom_range(255)));
          counted++;
          // Endings: table full, zero byte, lower byte, left open, overrun.
          ending  = $urandom_range(4);
          nbytes  = (ending == 0 || ending == 4) ? tab_len : $urandom_range(tab_len - 1);
          stepmax = (ending == 0 || ending == 4) ? 7 : 12;
          b       = $urandom_range(20, 1);
          last_b  = 0;
          for (int k = 0; k < nbytes; k++) begin
            queue_cmd(CMD_SET_BYTE, pick_position(), 3'($urandom_range(7)), 8'(b));
            counted++;
            last_b = b;
            b = b + $urandom_range(stepmax);
            if (b > 255) b = 255;
            // Other commands in the middle leave the sequence open.
            if ($urandom_range(99) < 10) begin
              case ($urandom_range(2))
                0:       queue_cmd(CMD_HTAB, pick_position(), 3'd0, 8'($urandom_range(255)));
                1:       queue_cmd(CMD_VTAB, pick_position(), 3'($urandom_range(7)), 8'd0);
                default: queue_cmd(CMD_HINC, pick_position(), 3'd0, 8'($urandom_range(12)));
              endcase
              counted++;
            end
          end
          case (ending)
            1: begin
              queue_cmd(CMD_SET_BYTE, pick_position(), 3'd0, 8'd0);
              counted++;
            end
            2: begin
              queue_cmd(CMD_SET_BYTE, pick_position(), 3'd0,
                        (last_b > 0) ? 8'($urandom_range(last_b - 1)) : 8'd0);
              counted++;
            end
            4: begin
              // Bytes past a full table find no sequence open.
              repeat ($urandom_range(3, 1)) begin
                queue_cmd(CMD_SET_BYTE, pick_position(), 3'd0, 8'($urandom_range(255)));
              end
            end
            default: ;
          endcase
          repeat ($urandom_range(4, 2)) begin
            queue_cmd(vert ? CMD_VTAB : CMD_HTAB, pick_position(), ch, 8'($urandom_range(255)));
            counted++;
          end
        end else if (pick < 85) begin
          queue_cmd($urandom_range(1) ? CMD_HTAB : CMD_VTAB, pick_position(),
                    3'($urandom_range(7)), 8'($urandom_range(255)));
          counted++;
        end else if (pick < 89) begin
          queue_cmd(CMD_CLEAR_ALL, pick_position(), 3'($urandom_range(7)),
                    8'($urandom_range(255)));
          counted++;
        end else if (pick < 95) begin
          case ($urandom_range(3))
            0:       queue_cmd(CMD_HINC, pick_position(), 3'd0, 8'd0);
            1:       queue_cmd(CMD_HINC, pick_position(), 3'd0, 8'd255);
            default: queue_cmd(CMD_HINC, pick_position(), 3'($urandom_range(7)),
                               8'($urandom_range(255)));
          endcase
          counted++;
        end else begin
          // Noise: a NOP, or a set byte that lands in any sequence left open; not counted.
          queue_cmd($urandom_range(1) ? CMD_NOP : CMD_SET_BYTE, pick_position(),
                    3'($urandom_range(7)), 8'($urandom_range(255)));
        end
      end
    end

    // Every command produces exactly one result, so once all are checked the
    // block is idle; a short settle catches any stray extra result.
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
